// ----- rtl/itl_pkg.sv -----
// Shared constants and types for the interpolated table lookup unit.
// Used by the top level, the interpolation datapath and the port checker.
package itl_pkg;

   // Table geometry and sample format
   localparam int TABLE_DEPTH   = 1024;
   localparam int FRACTION_BITS = 16;
   localparam int SAMPLE_BITS   = 24;
   localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
   localparam int LENGTH_BITS   = ADDR_BITS + 1;
   localparam int LENGTH_RESET  = TABLE_DEPTH;

   // Request field widths
   localparam int INDEX_BITS    = 10;
   localparam int INT_BITS      = 10;
   localparam int POSITION_BITS = INT_BITS + FRACTION_BITS;

   // Request beat layout: table_index, table_sample, position from bit 0 up
   localparam int INDEX_LSB     = 0;
   localparam int SAMPLE_LSB    = INDEX_LSB + INDEX_BITS;
   localparam int POSITION_LSB  = SAMPLE_LSB + SAMPLE_BITS;
   localparam int REQ_USED_BITS = POSITION_LSB + POSITION_BITS;
   localparam int REQ_DATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   // Datapath widths
   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int PROD_BITS = FRACTION_BITS + 1 + DIFF_BITS;

   // Register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [0:0] REG_TABLE_LENGTH = 1'b0;

   // Request kinds carried in tuser
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Control that travels with each pipeline stage
   typedef struct packed {
      logic valid;
      logic range_error;
   } itl_ctl_type;

endpackage

// ----- rtl/itl_lerp.sv -----
// Interpolation datapath: difference, fractional multiply, floor shift and add.
// Three register stages, the last one the result register. Uses itl_pkg.
module itl_lerp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  itl_pkg::itl_ctl_type                  in_ctl,
   input  logic signed [itl_pkg::SAMPLE_BITS-1:0]   in_a,
   input  logic signed [itl_pkg::SAMPLE_BITS-1:0]   in_b,
   input  logic        [itl_pkg::FRACTION_BITS-1:0] in_frac,
   output itl_pkg::itl_ctl_type                  out_ctl,
   output logic signed [itl_pkg::SAMPLE_BITS-1:0]   out_sample
);

   // Stage 2: difference of neighbors
   itl_pkg::itl_ctl_type                        s2_ctl_ff;
   logic signed [itl_pkg::DIFF_BITS-1:0]        s2_diff_ff, s2_diff_in;
   logic signed [itl_pkg::SAMPLE_BITS-1:0]      s2_a_ff;
   logic        [itl_pkg::FRACTION_BITS-1:0]    s2_frac_ff;

   // Stage 3: scaled difference
   itl_pkg::itl_ctl_type                        s3_ctl_ff;
   logic signed [itl_pkg::PROD_BITS-1:0]        s3_prod_ff, s3_prod_in;
   logic signed [itl_pkg::SAMPLE_BITS-1:0]      s3_a_ff;

   // Stage 4: result register
   itl_pkg::itl_ctl_type                        s4_ctl_ff;
   logic signed [itl_pkg::SAMPLE_BITS-1:0]      s4_sample_ff, s4_sample_in;
   logic signed [itl_pkg::PROD_BITS-1:0]        step_full;

   assign s2_diff_in = itl_pkg::DIFF_BITS'(in_b) - itl_pkg::DIFF_BITS'(in_a);

   assign s3_prod_in = itl_pkg::PROD_BITS'(
      $signed({1'b0, s2_frac_ff}) * s2_diff_ff);

   // Arithmetic shift rounds toward minus infinity; the sum stays in range
   assign step_full    = s3_prod_ff >>> itl_pkg::FRACTION_BITS;
   assign s4_sample_in = s3_ctl_ff.range_error ? '0 :
                         s3_a_ff + step_full[itl_pkg::SAMPLE_BITS-1:0];

   // Control: clear on reset, advance together
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
      end else if (advance) begin
         s2_ctl_ff <= in_ctl;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   // Payload: hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_diff_ff   <= s2_diff_in;
         s2_a_ff      <= in_a;
         s2_frac_ff   <= in_frac;
         s3_prod_ff   <= s3_prod_in;
         s3_a_ff      <= s2_a_ff;
         s4_sample_ff <= s4_sample_in;
      end
   end

   assign out_ctl    = s4_ctl_ff;
   assign out_sample = s4_sample_ff;

endmodule

// ----- rtl/interpolated_table_lookup_unit.sv -----
// Top level: sample table memory, register port and lookup pipeline.
// Depends on itl_pkg and itl_lerp.
//
//  channel  direction  handshake              beat contents
//  req      in         req_tvalid/req_tready  tuser op; tdata index, sample, position
//  rsp      out        rsp_tvalid/rsp_tready  tuser range_error; tdata out_sample
//  csr      in/out     csr_psel/csr_penable   table_length at byte address 0
//
// One beat per cycle while no result is held; a lookup result passes through the
// table read stage, difference, multiply and result register. A write beat gives
// no result and updates the table at the edge it is taken.
// A held result stalls the whole pipeline; req_tready drops only then.
// Reset clears valid bits and sets table_length to 1024; the table itself
// holds unknown data until written.
module interpolated_table_lookup_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [9:0] table_index, [33:10] table_sample, [59:34] position, [63:60] zero
   input  logic [itl_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // [0] op
   input  logic                                  req_tuser,
   // Result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [23:0] out_sample
   output logic [itl_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // [0] range_error
   output logic                                  rsp_tuser,
   // Register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [itl_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [itl_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [itl_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   logic [itl_pkg::LENGTH_BITS-1:0]     table_length_ff;
   logic [itl_pkg::LENGTH_BITS-1:0]     len_eff;
   logic                                csr_write;
   logic [0:0]                          csr_reg;

   logic                                advance;
   logic                                req_take;
   logic [itl_pkg::INDEX_BITS-1:0]      req_index;
   logic signed [itl_pkg::SAMPLE_BITS-1:0] req_sample;
   logic [itl_pkg::POSITION_BITS-1:0]   req_position;
   logic [itl_pkg::INT_BITS-1:0]        pos_int;
   logic [itl_pkg::FRACTION_BITS-1:0]   pos_frac;
   logic [itl_pkg::LENGTH_BITS-1:0]     pos_next;
   logic [itl_pkg::ADDR_BITS-1:0]       addr_a;
   logic [itl_pkg::ADDR_BITS-1:0]       addr_b;
   itl_pkg::itl_ctl_type                s1_ctl_in;

   logic signed [itl_pkg::SAMPLE_BITS-1:0] table_mem [itl_pkg::TABLE_DEPTH];

   itl_pkg::itl_ctl_type                s1_ctl_ff;
   logic signed [itl_pkg::SAMPLE_BITS-1:0] s1_a_ff;
   logic signed [itl_pkg::SAMPLE_BITS-1:0] s1_b_ff;
   logic [itl_pkg::FRACTION_BITS-1:0]   s1_frac_ff;

   itl_pkg::itl_ctl_type                out_ctl;
   logic signed [itl_pkg::SAMPLE_BITS-1:0] out_sample;

   // Register port: always ready, one register at word 0
   assign csr_pready = 1'b1;
   assign csr_reg    = csr_paddr[itl_pkg::CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_reg == itl_pkg::REG_TABLE_LENGTH);
   assign csr_prdata = (csr_reg == itl_pkg::REG_TABLE_LENGTH) ?
                       itl_pkg::CSR_DATA_BITS'(table_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= itl_pkg::LENGTH_BITS'(itl_pkg::LENGTH_RESET);
      end else if (csr_write) begin
         table_length_ff <= csr_pwdata[itl_pkg::LENGTH_BITS-1:0];
      end
   end

   // Clamp the active length to the table depth
   assign len_eff = (table_length_ff > itl_pkg::LENGTH_BITS'(itl_pkg::TABLE_DEPTH)) ?
                    itl_pkg::LENGTH_BITS'(itl_pkg::TABLE_DEPTH) : table_length_ff;

   // Whole pipeline moves unless a result is held at the output
   assign advance    = !out_ctl.valid || rsp_tready;
   assign req_tready = advance;
   assign req_take   = req_tvalid && req_tready;

   // Unpack the request beat
   assign req_index    = req_tdata[itl_pkg::SAMPLE_LSB-1:itl_pkg::INDEX_LSB];
   assign req_sample   = req_tdata[itl_pkg::POSITION_LSB-1:itl_pkg::SAMPLE_LSB];
   assign req_position = req_tdata[itl_pkg::REQ_USED_BITS-1:itl_pkg::POSITION_LSB];
   assign pos_int      = req_position[itl_pkg::POSITION_BITS-1:itl_pkg::FRACTION_BITS];
   assign pos_frac     = req_position[itl_pkg::FRACTION_BITS-1:0];

   // Neighbor index wraps to entry 0 at the active length
   assign pos_next = itl_pkg::LENGTH_BITS'(pos_int) + itl_pkg::LENGTH_BITS'(1);
   assign addr_a   = itl_pkg::ADDR_BITS'(pos_int);
   assign addr_b   = (pos_next >= len_eff) ? '0 : pos_next[itl_pkg::ADDR_BITS-1:0];

   always_comb begin
      s1_ctl_in.valid       = req_take && (req_tuser == itl_pkg::OP_LOOKUP);
      s1_ctl_in.range_error = (itl_pkg::LENGTH_BITS'(pos_int) >= len_eff);
   end

   // Table memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (req_take && (req_tuser == itl_pkg::OP_WRITE)) begin
         table_mem[req_index] <= req_sample;
      end
      if (advance) begin
         s1_a_ff <= table_mem[addr_a];
         s1_b_ff <= table_mem[addr_b];
      end
   end

   // Stage 1 payload and control
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_frac_ff <= pos_frac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   itl_lerp u_lerp (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_ctl     (s1_ctl_ff),
      .in_a       (s1_a_ff),
      .in_b       (s1_b_ff),
      .in_frac    (s1_frac_ff),
      .out_ctl    (out_ctl),
      .out_sample (out_sample)
   );

   // Result beat
   assign rsp_tvalid = out_ctl.valid;
   assign rsp_tuser  = out_ctl.range_error;
   assign rsp_tdata  = itl_pkg::RSP_DATA_BITS'(unsigned'(out_sample));

endmodule

// ----- rtl/itl_checker.sv -----
// Port-level checker for the interpolated table lookup unit, bound to the top.
// Depends on itl_pkg for port widths.
module itl_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [itl_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_pready
);

   // Held result beat keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // A range error always carries a zero sample
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("range error with nonzero sample");

   // A stalled result blocks new request beats
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   // With the pipeline never stalled in between, a result that appears after idle
   // comes from a lookup beat taken when it entered the table read stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && $past(req_tready, 1) && $past(req_tready, 2) &&
      $past(req_tready, 3) && $past(req_tready, 4) |->
         $past(req_tvalid && req_tready && (req_tuser == itl_pkg::OP_LOOKUP), 4))
      else $error("result without a matching lookup beat");

   // Register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port not ready");

endmodule

bind interpolated_table_lookup_unit itl_checker u_itl_checker (.*);

// ----- bench/tb_interpolated_table_lookup_unit.sv -----
// Self-checking bench for the interpolated table lookup unit: table writes and lookups go
// in on the request stream, and each lookup result is checked against a local model.
// Depends on itl_pkg and the interpolated_table_lookup_unit RTL.
module tb_interpolated_table_lookup_unit;

   localparam logic [itl_pkg::CSR_ADDR_BITS-1:0] TABLE_LENGTH_ADDR =
      itl_pkg::CSR_ADDR_BITS'(4 * itl_pkg::REG_TABLE_LENGTH);
   // Register index 1 has no register behind it
   localparam logic [itl_pkg::CSR_ADDR_BITS-1:0] SPARE_REG_ADDR =
      itl_pkg::CSR_ADDR_BITS'(4);
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int RUN_LIMIT    = 2_000_000;

   typedef struct packed {
      logic [itl_pkg::SAMPLE_BITS-1:0] sample;
      logic                            range_error;
   } lookup_result_type;

   logic                                  clock       = 1'b0;
   logic                                  reset       = 1'b1;
   logic                                  req_tvalid  = 1'b0;
   logic                                  req_tready;
   logic [itl_pkg::REQ_DATA_BITS-1:0]     req_tdata   = '0;
   logic                                  req_tuser   = itl_pkg::OP_WRITE;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready  = 1'b0;
   logic [itl_pkg::RSP_DATA_BITS-1:0]     rsp_tdata;
   logic                                  rsp_tuser;
   logic                                  csr_psel    = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite  = 1'b0;
   logic [itl_pkg::CSR_ADDR_BITS-1:0]     csr_paddr   = '0;
   logic [itl_pkg::CSR_DATA_BITS-1:0]     csr_pwdata  = '0;
   logic [itl_pkg::CSR_DATA_BITS-1:0]     csr_prdata;
   logic                                  csr_pready;

   // Local copy of the table, the active length and the lookups still in flight
   logic signed [itl_pkg::SAMPLE_BITS-1:0] shadow_table [itl_pkg::TABLE_DEPTH];
   bit                                     entry_written [itl_pkg::TABLE_DEPTH];
   logic [itl_pkg::LENGTH_BITS-1:0]        active_length =
      itl_pkg::LENGTH_BITS'(itl_pkg::LENGTH_RESET);
   lookup_result_type                      pending_results [$];
   int                                     mismatch_count = 0;
   int                                     idle_pct = 0;
   int                                     stall_pct = 0;

   interpolated_table_lookup_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #RUN_LIMIT;
      $display("tb_interpolated_table_lookup_unit: done, errors");
      $finish;
   end

   // Interpolate between entry y and its neighbour, flooring the scaled difference
   function automatic lookup_result_type interpolate(
      input logic [itl_pkg::POSITION_BITS-1:0] position);
      int unsigned       span;
      int unsigned       y;
      int unsigned       yn;
      longint            a;
      longint            b;
      longint            f;
      lookup_result_type r;
      span = (active_length > itl_pkg::TABLE_DEPTH) ? itl_pkg::TABLE_DEPTH : active_length;
      y = position >> itl_pkg::FRACTION_BITS;
      f = position[itl_pkg::FRACTION_BITS-1:0];
      r.sample = '0;
      r.range_error = 1'b1;
      if (y < span) begin
         yn = (y + 1 >= span) ? 0 : y + 1;
         a = shadow_table[y];
         b = shadow_table[yn];
         r.sample = itl_pkg::SAMPLE_BITS'(a + ((f * (b - a)) >>> itl_pkg::FRACTION_BITS));
         r.range_error = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [itl_pkg::POSITION_BITS-1:0] pos_at(input int unsigned y,
                                                                input int unsigned frac);
      return {itl_pkg::INT_BITS'(y), itl_pkg::FRACTION_BITS'(frac)};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] expected,
                                  input logic [63:0] actual);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, expected, actual);
   endtask

   // Stall the result stream at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Check every result beat against the oldest pending lookup
   always @(posedge clock) begin : result_check
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", '0, 64'({rsp_tuser, rsp_tdata}));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.sample)
               report_mismatch("out_sample", 64'(want.sample), 64'(rsp_tdata));
            if (rsp_tuser !== want.range_error)
               report_mismatch("range_error", 64'(want.range_error), 64'(rsp_tuser));
         end
      end
   end

   // Present one request beat after a random idle gap, then hold until taken
   task automatic send_beat(input logic op, input logic [itl_pkg::INDEX_BITS-1:0] index,
                            input logic [itl_pkg::SAMPLE_BITS-1:0] sample,
                            input logic [itl_pkg::POSITION_BITS-1:0] position);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= itl_pkg::REQ_DATA_BITS'({position, sample, index});
      do @(posedge clock); while (!req_tready);
      if (op == itl_pkg::OP_WRITE) begin
         shadow_table[index]  = sample;
         entry_written[index] = 1'b1;
      end else begin
         pending_results.push_back(interpolate(position));
      end
   endtask

   task automatic csr_access(input logic is_write,
                             input logic [itl_pkg::CSR_ADDR_BITS-1:0] addr,
                             input logic [itl_pkg::CSR_DATA_BITS-1:0] wdata,
                             output logic [itl_pkg::CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (is_write && addr == TABLE_LENGTH_ADDR)
         active_length = wdata[itl_pkg::LENGTH_BITS-1:0];
   endtask

   // Drain the pipeline, write a register, then read table_length back
   task automatic set_register(input logic [itl_pkg::CSR_ADDR_BITS-1:0] addr,
                               input logic [itl_pkg::CSR_DATA_BITS-1:0] value);
      logic [itl_pkg::CSR_DATA_BITS-1:0] readback;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_access(1'b1, addr, value, readback);
      csr_access(1'b0, TABLE_LENGTH_ADDR, '0, readback);
      if (readback[itl_pkg::LENGTH_BITS-1:0] !== active_length)
         report_mismatch("table_length readback", 64'(active_length), 64'(readback));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Full-scale samples, fractions at both ends, rounding of negative slopes, wrap at 1023
   task automatic test_interpolation_extremes();
      set_register(TABLE_LENGTH_ADDR, itl_pkg::LENGTH_RESET);
      send_beat(itl_pkg::OP_WRITE, 10'd0,    24'h800000, '0);
      send_beat(itl_pkg::OP_WRITE, 10'd1,    24'h7fffff, '1);
      send_beat(itl_pkg::OP_WRITE, 10'd2,    24'h000000, '0);
      send_beat(itl_pkg::OP_WRITE, 10'd1023, 24'hffffff, '1);
      send_beat(itl_pkg::OP_LOOKUP, '1, '1, pos_at(0, 0));
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(0, 16'hffff));
      send_beat(itl_pkg::OP_LOOKUP, '1, '0, pos_at(1, 16'hffff));
      send_beat(itl_pkg::OP_LOOKUP, '0, '1, pos_at(1, 16'h0001));
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(1023, 16'h8000));
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, '1);
      // Overwrite right behind a lookup of the same entry
      send_beat(itl_pkg::OP_WRITE, 10'd1023, 24'h7fffff, '0);
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(1023, 16'h0001));
   endtask

   // Short tables, empty table, length past the depth, and a write to no register
   task automatic test_length_corners();
      set_register(TABLE_LENGTH_ADDR, 2);
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(1, 16'h8000));
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(2, 0));
      set_register(TABLE_LENGTH_ADDR, 1);
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(0, 16'hc000));
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(1, 0));
      set_register(TABLE_LENGTH_ADDR, 0);
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(0, 0));
      set_register(TABLE_LENGTH_ADDR, 1500);
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(1023, 16'h4000));
      set_register(SPARE_REG_ADDR, 5);
      send_beat(itl_pkg::OP_LOOKUP, '0, '0, pos_at(1023, 16'h2000));
   endtask

   // Mix writes and lookups; fill in a missing entry instead of reading it
   task automatic send_random_beat();
      int unsigned                        span;
      int unsigned                        y;
      int unsigned                        yn;
      logic [itl_pkg::FRACTION_BITS-1:0]  frac;
      span = (active_length > itl_pkg::TABLE_DEPTH) ? itl_pkg::TABLE_DEPTH : active_length;
      if ($urandom_range(99) < 35) begin
         send_beat(itl_pkg::OP_WRITE, itl_pkg::INDEX_BITS'($urandom),
                   itl_pkg::SAMPLE_BITS'($urandom), itl_pkg::POSITION_BITS'($urandom));
         return;
      end
      if (span != 0 && $urandom_range(99) < 75)
         y = $urandom_range(span - 1);
      else
         y = $urandom_range(itl_pkg::TABLE_DEPTH - 1);
      yn = (y + 1 >= span) ? 0 : y + 1;
      frac = itl_pkg::FRACTION_BITS'($urandom);
      if (y < span && !entry_written[y])
         send_beat(itl_pkg::OP_WRITE, itl_pkg::INDEX_BITS'(y),
                   itl_pkg::SAMPLE_BITS'($urandom), itl_pkg::POSITION_BITS'($urandom));
      else if (y < span && !entry_written[yn])
         send_beat(itl_pkg::OP_WRITE, itl_pkg::INDEX_BITS'(yn),
                   itl_pkg::SAMPLE_BITS'($urandom), itl_pkg::POSITION_BITS'($urandom));
      else
         send_beat(itl_pkg::OP_LOOKUP, itl_pkg::INDEX_BITS'($urandom),
                   itl_pkg::SAMPLE_BITS'($urandom), pos_at(y, frac));
   endtask

   task automatic run_phase(input int unsigned length, input int idle, input int stall,
                            input int count);
      set_register(TABLE_LENGTH_ADDR, length);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) send_random_beat();
   endtask

   // Random traffic over several lengths, idle patterns and stall patterns
   task automatic test_random_traffic();
      run_phase(itl_pkg::LENGTH_RESET, 0, 0, 350);
      run_phase(2, 84, 0, 150);
      run_phase($urandom_range(1024, 2), 0, 84, 350);
      run_phase($urandom_range(1023, 3), 14, 14, 350);
      run_phase(2047, 0, 0, 150);
      run_phase(itl_pkg::LENGTH_RESET, 14, 14, 150);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_interpolation_extremes();
      test_length_corners();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("tb_interpolated_table_lookup_unit: done, clean");
      else
         $display("tb_interpolated_table_lookup_unit: done, errors");
      $finish;
   end

endmodule
